/* design/scanline_raster_effects_unit_macros.svh */
// Assertion macros shared by the raster-effects unit RTL.
`ifndef SCANLINE_RASTER_EFFECTS_UNIT_MACROS_SVH
`define SCANLINE_RASTER_EFFECTS_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked property, quiet while reset is high.
`define SRFX_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also checked during reset.
`define SRFX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRFX_ASSERT(lbl, clk, rst, prop, msg)
`define SRFX_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* design/srfx_pkg.sv */
// Types and constants of the scanline raster-effects unit.
`timescale 1ns / 1ps
`default_nettype none
package srfx_pkg;

   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_HSYNC = 2'd2;

   localparam logic [4:0] OFF_SCROLL_LO = 5'h00;
   localparam logic [4:0] OFF_SCROLL_HI = 5'h01;
   localparam logic [4:0] OFF_PALETTE   = 5'h02;
   localparam logic [4:0] OFF_IRQ_LO    = 5'h04;
   localparam logic [4:0] OFF_IRQ_HI    = 5'h05;
   localparam logic [4:0] OFF_IRQ_EN    = 5'h06;
   localparam logic [4:0] OFF_IRQ_STAT  = 5'h08;
   localparam logic [4:0] OFF_TABLE_ON  = 5'h10;
   localparam logic [4:0] OFF_LOAD_LO   = 5'h12;
   localparam logic [4:0] OFF_LOAD_HI   = 5'h13;
   localparam logic [4:0] OFF_DATA_PORT = 5'h14;
   localparam logic [4:0] OFF_LINE_LO   = 5'h16;
   localparam logic [4:0] OFF_LINE_HI   = 5'h17;

   // work left for the cycle after accept
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_HSYNC = 2'd2;

   localparam logic [1:0] PHASE_LO  = 2'd0;
   localparam logic [1:0] PHASE_MID = 2'd1;
   localparam logic [1:0] PHASE_HI  = 2'd2;

   typedef struct packed {
      logic        rd_en;
      logic [8:0]  rd_addr;
      logic        wr_en;
      logic [8:0]  wr_addr;
      logic [23:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [15:0] scroll_out;
      logic [7:0]  palette_out;
      logic        irq_pending;
      logic        irq_raised;
   } result_type;

endpackage
`default_nettype wire

/* design/srfx_channels.sv */
// Valid/ready channel interfaces for bus and hsync beats and for results.
`timescale 1ns / 1ps
`default_nettype none
interface srfx_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [4:0] reg_offset;
   logic [7:0] write_data;
   logic [8:0] line_number;

   modport source (output valid, mode, reg_offset, write_data, line_number, input ready);
   modport sink   (input valid, mode, reg_offset, write_data, line_number, output ready);
endinterface

interface srfx_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic [15:0] scroll_out;
   logic [7:0]  palette_out;
   logic        irq_pending;
   logic        irq_raised;

   modport source (output valid, read_data, scroll_out, palette_out, irq_pending, irq_raised,
                   input ready);
   modport sink   (input valid, read_data, scroll_out, palette_out, irq_pending, irq_raised,
                   output ready);
endinterface
`default_nettype wire

/* design/scanline_raster_effects_unit.sv */
// Top level of the scanline raster-effects unit.
//
//   channel   dir  beat contents
//   req_chan  in   mode, reg_offset, write_data, line_number
//   rsp_chan  out  read_data, scroll_out, palette_out, irq_pending, irq_raised
//
// Every beat has an accept cycle and then a finish cycle in which the
// table memory's registered read returns and any write-back is done.
// One beat is in flight at a time; the result sits in an output register.
// After reset the table (TABLE_LINES entries, 262 by default) is zeroed
// with req_chan.ready low.
// A stalled result holds rsp_chan; the next beat is taken in the cycle it drains.
`timescale 1ns / 1ps
`default_nettype none
`include "scanline_raster_effects_unit_macros.svh"
module scanline_raster_effects_unit #(
   parameter int TABLE_LINES = 262
) (
   input logic       clock,
   input logic       reset,
   srfx_req_if.sink  req_chan,
   srfx_rsp_if.source rsp_chan
);
   import srfx_pkg::*;

   mem_req_type mem_req;
   result_type  result;
   result_type  rsp_data_ff, rsp_data_in;
   logic [23:0] mem_rd_data;
   logic        clearing;
   logic        done;
   logic        accept;
   logic        rsp_valid_ff, rsp_valid_in;

   assign req_chan.ready = !done && !clearing && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   srfx_regs #(
      .TABLE_LINES (TABLE_LINES)
   ) u_regs (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (req_chan.mode),
      .reg_offset  (req_chan.reg_offset),
      .write_data  (req_chan.write_data),
      .line_number (req_chan.line_number),
      .mem_rd_data (mem_rd_data),
      .mem_req     (mem_req),
      .result      (result),
      .done        (done)
   );

   srfx_line_mem #(
      .TABLE_LINES (TABLE_LINES)
   ) u_line_mem (
      .clock    (clock),
      .reset    (reset),
      .mem_req  (mem_req),
      .rd_data  (mem_rd_data),
      .clearing (clearing)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_data   = rsp_data_ff.read_data;
   assign rsp_chan.scroll_out  = rsp_data_ff.scroll_out;
   assign rsp_chan.palette_out = rsp_data_ff.palette_out;
   assign rsp_chan.irq_pending = rsp_data_ff.irq_pending;
   assign rsp_chan.irq_raised  = rsp_data_ff.irq_raised;

   `SRFX_ASSERT(a_finish_after_accept, clock, reset, accept |=> done, "accepted beat did not reach finish cycle")
   `SRFX_ASSERT(a_out_free_at_finish, clock, reset, done |-> !rsp_valid_ff, "result would overwrite an untaken result")
   `SRFX_ASSERT(a_no_accept_in_sweep, clock, reset, clearing |-> !accept, "beat accepted during table clearing")
   `SRFX_ASSERT_ALWAYS(a_idle_in_reset, clock, reset |=> (!rsp_valid_ff && !done), "control not cleared by reset")

endmodule
`default_nettype wire

/* design/srfx_line_mem.sv */
// Per-line table memory with a zeroing sweep after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "scanline_raster_effects_unit_macros.svh"
module srfx_line_mem #(
   parameter int TABLE_LINES = 262
) (
   input  logic                 clock,
   input  logic                 reset,
   input  srfx_pkg::mem_req_type mem_req,
   output logic [23:0]          rd_data,
   output logic                 clearing
);
   import srfx_pkg::*;

   localparam int IDX_W = (TABLE_LINES > 1) ? $clog2(TABLE_LINES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_LINES - 1);

   logic [23:0]      mem [TABLE_LINES];
   logic [23:0]      rd_data_ff;
   logic             clearing_ff, clearing_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;

   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + IDX_W'(1);
         if (clr_idx_ff == LAST_IDX) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // single write port, shared between the sweep and write-back
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[IDX_W-1:0]] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr[IDX_W-1:0]];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

   `SRFX_ASSERT(a_no_read_in_sweep, clock, reset, clearing_ff |-> !mem_req.rd_en, "read in sweep")
   `SRFX_ASSERT(a_no_write_in_sweep, clock, reset, clearing_ff |-> !mem_req.wr_en, "write in sweep")
   `SRFX_ASSERT(a_sweep_full, clock, reset, $fell(clearing_ff) |-> ($past(clr_idx_ff) == LAST_IDX), "short sweep")

endmodule
`default_nettype wire

/* design/srfx_regs.sv */
// Register bank, bus decode, IRQ logic and table read-modify-write control.
`timescale 1ns / 1ps
`default_nettype none
`include "scanline_raster_effects_unit_macros.svh"
module srfx_regs #(
   parameter int TABLE_LINES = 262
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            mode,
   input  logic [4:0]            reg_offset,
   input  logic [7:0]            write_data,
   input  logic [8:0]            line_number,
   input  logic [23:0]           mem_rd_data,
   output srfx_pkg::mem_req_type mem_req,
   output srfx_pkg::result_type  result,
   output logic                  done
);
   import srfx_pkg::*;

   localparam logic [9:0] LINES = 10'(TABLE_LINES);

   logic [15:0] scroll_ff, scroll_in;
   logic [7:0]  palette_ff, palette_in;
   logic [8:0]  irq_line_ff, irq_line_in;
   logic        irq_en_ff, irq_en_in;
   logic        irq_flag_ff, irq_flag_in;
   logic        table_on_ff, table_on_in;
   logic [8:0]  load_addr_ff, load_addr_in;
   logic [1:0]  load_phase_ff, load_phase_in;
   logic [8:0]  line_pos_ff, line_pos_in;
   logic [15:0] app_scroll_ff, app_scroll_in;
   logic [7:0]  app_palette_ff, app_palette_in;
   logic        pend_ff, pend_in;
   logic [1:0]  op_ff, op_in;
   logic [7:0]  rd_ff, rd_in;
   logic        raised_ff, raised_in;
   logic [1:0]  wb_phase_ff, wb_phase_in;
   logic [8:0]  wb_addr_ff, wb_addr_in;
   logic [7:0]  wb_byte_ff, wb_byte_in;

   logic [7:0]  read_byte;
   logic [8:0]  line_pos_inc;
   logic [23:0] merged;

   always_comb begin
      unique case (reg_offset)
         OFF_SCROLL_LO: read_byte = scroll_ff[7:0];
         OFF_SCROLL_HI: read_byte = scroll_ff[15:8];
         OFF_PALETTE:   read_byte = palette_ff;
         OFF_IRQ_LO:    read_byte = irq_line_ff[7:0];
         OFF_IRQ_HI:    read_byte = {7'd0, irq_line_ff[8]};
         OFF_IRQ_EN:    read_byte = {7'd0, irq_en_ff};
         OFF_IRQ_STAT:  read_byte = {7'd0, irq_flag_ff};
         OFF_TABLE_ON:  read_byte = {7'd0, table_on_ff};
         OFF_LOAD_LO:   read_byte = load_addr_ff[7:0];
         OFF_LOAD_HI:   read_byte = {7'd0, load_addr_ff[8]};
         OFF_LINE_LO:   read_byte = line_pos_ff[7:0];
         OFF_LINE_HI:   read_byte = {7'd0, line_pos_ff[8]};
         default:       read_byte = 8'd0;
      endcase
   end

   assign line_pos_inc = line_pos_ff + 9'd1;

   always_comb begin
      unique case (wb_phase_ff)
         PHASE_LO:  merged = {mem_rd_data[23:8], wb_byte_ff};
         PHASE_MID: merged = {mem_rd_data[23:16], wb_byte_ff, mem_rd_data[7:0]};
         default:   merged = {wb_byte_ff, mem_rd_data[15:0]};
      endcase
   end

   always_comb begin
      scroll_in      = scroll_ff;
      palette_in     = palette_ff;
      irq_line_in    = irq_line_ff;
      irq_en_in      = irq_en_ff;
      irq_flag_in    = irq_flag_ff;
      table_on_in    = table_on_ff;
      load_addr_in   = load_addr_ff;
      load_phase_in  = load_phase_ff;
      line_pos_in    = line_pos_ff;
      app_scroll_in  = app_scroll_ff;
      app_palette_in = app_palette_ff;
      pend_in        = pend_ff;
      op_in          = op_ff;
      rd_in          = rd_ff;
      raised_in      = raised_ff;
      wb_phase_in    = wb_phase_ff;
      wb_addr_in     = wb_addr_ff;
      wb_byte_in     = wb_byte_ff;
      mem_req        = '0;

      if (accept) begin
         pend_in   = 1'b1;
         op_in     = OP_NONE;
         rd_in     = 8'd0;
         raised_in = 1'b0;
         unique case (mode)
            MODE_READ: begin
               rd_in = read_byte;
            end
            MODE_WRITE: begin
               unique case (reg_offset)
                  OFF_SCROLL_LO: scroll_in[7:0]  = write_data;
                  OFF_SCROLL_HI: scroll_in[15:8] = write_data;
                  OFF_PALETTE:   palette_in      = write_data;
                  OFF_IRQ_LO:    irq_line_in[7:0] = write_data;
                  OFF_IRQ_HI:    irq_line_in[8]  = write_data[0];
                  OFF_IRQ_EN:    irq_en_in       = write_data[0];
                  OFF_IRQ_STAT: begin
                     if (write_data[0]) begin
                        irq_flag_in = 1'b0;
                     end
                  end
                  OFF_TABLE_ON: begin
                     table_on_in = write_data[0];
                     if (write_data[0]) begin
                        line_pos_in = 9'd0;
                     end
                  end
                  OFF_LOAD_LO: begin
                     load_addr_in[7:0] = write_data;
                     load_phase_in     = PHASE_LO;
                  end
                  OFF_LOAD_HI: begin
                     load_addr_in[8] = write_data[0];
                     load_phase_in   = PHASE_LO;
                  end
                  OFF_DATA_PORT: begin
                     // bytes past the table end are dropped
                     if ({1'b0, load_addr_ff} < LINES) begin
                        op_in           = OP_LOAD;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = load_addr_ff;
                        wb_addr_in      = load_addr_ff;
                        wb_phase_in     = load_phase_ff;
                        wb_byte_in      = write_data;
                        unique case (load_phase_ff)
                           PHASE_LO:  load_phase_in = PHASE_MID;
                           PHASE_MID: load_phase_in = PHASE_HI;
                           default: begin
                              load_phase_in = PHASE_LO;
                              load_addr_in  = load_addr_ff + 9'd1;
                           end
                        endcase
                     end
                  end
                  default: ;
               endcase
            end
            MODE_HSYNC: begin
               if (table_on_ff) begin
                  if ({1'b0, line_pos_ff} < LINES) begin
                     op_in           = OP_HSYNC;
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = line_pos_ff;
                  end
                  line_pos_in = ({1'b0, line_pos_inc} >= LINES) ? 9'd0 : line_pos_inc;
               end else begin
                  app_scroll_in  = scroll_ff;
                  app_palette_in = palette_ff;
               end
               if (irq_en_ff && (line_number == irq_line_ff) && !irq_flag_ff) begin
                  irq_flag_in = 1'b1;
                  raised_in   = 1'b1;
               end
            end
            default: ;
         endcase
      end

      // finish cycle: table data is back from the memory
      if (pend_ff) begin
         pend_in = 1'b0;
         op_in   = OP_NONE;
         unique case (op_ff)
            OP_LOAD: begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = wb_addr_ff;
               mem_req.wr_data = merged;
            end
            OP_HSYNC: begin
               app_scroll_in  = mem_rd_data[15:0];
               app_palette_in = mem_rd_data[23:16];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_ff      <= '0;
         palette_ff     <= '0;
         irq_line_ff    <= '0;
         irq_en_ff      <= 1'b0;
         irq_flag_ff    <= 1'b0;
         table_on_ff    <= 1'b0;
         load_addr_ff   <= '0;
         load_phase_ff  <= PHASE_LO;
         line_pos_ff    <= '0;
         app_scroll_ff  <= '0;
         app_palette_ff <= '0;
         pend_ff        <= 1'b0;
         op_ff          <= OP_NONE;
      end else begin
         scroll_ff      <= scroll_in;
         palette_ff     <= palette_in;
         irq_line_ff    <= irq_line_in;
         irq_en_ff      <= irq_en_in;
         irq_flag_ff    <= irq_flag_in;
         table_on_ff    <= table_on_in;
         load_addr_ff   <= load_addr_in;
         load_phase_ff  <= load_phase_in;
         line_pos_ff    <= line_pos_in;
         app_scroll_ff  <= app_scroll_in;
         app_palette_ff <= app_palette_in;
         pend_ff        <= pend_in;
         op_ff          <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff       <= rd_in;
      raised_ff   <= raised_in;
      wb_phase_ff <= wb_phase_in;
      wb_addr_ff  <= wb_addr_in;
      wb_byte_ff  <= wb_byte_in;
   end

   assign result.read_data   = rd_ff;
   assign result.scroll_out  = app_scroll_in;
   assign result.palette_out = app_palette_in;
   assign result.irq_pending = irq_flag_ff;
   assign result.irq_raised  = raised_ff;
   assign done               = pend_ff;

   `SRFX_ASSERT(a_raise_sets_flag, clock, reset, (pend_ff && raised_ff) |-> irq_flag_ff, "raise w/o flag")
   `SRFX_ASSERT(a_phase_legal, clock, reset, load_phase_ff <= PHASE_HI, "bad load phase")
   `SRFX_ASSERT(a_line_pos_in_table, clock, reset, 10'(line_pos_ff) < LINES, "line pos past table")

endmodule
`default_nettype wire
